FILE: src/osva_pkg.sv
// Package for the orthogonal slice voxel address generator.
// Holds the register indexes, plane and view codes, and the structs passed between modules.
// No dependencies.
package osva_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int DIM_W = 10;
    localparam int COORD_W = 9;
    localparam int ADDR_W = 27;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_PLANE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_INDEX = 3'd5;

    localparam logic [1:0] CUT_AXIAL = 2'd0;
    localparam logic [1:0] CUT_SAGITTAL = 2'd1;
    localparam logic [1:0] CUT_CORONAL = 2'd2;

    localparam logic VIEW_RADIOLOGIST = 1'b0;
    localparam logic VIEW_NEUROSURGEON = 1'b1;

    localparam logic [DIM_W-1:0] SIZE_RESET = 10'd256;

    typedef struct packed {
        logic [DIM_W-1:0]   size_x;
        logic [DIM_W-1:0]   size_y;
        logic [DIM_W-1:0]   size_z;
        logic               view_mode;
        logic [1:0]         cut_plane;
        logic [COORD_W-1:0] slice_index;
    } t_cfg;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] z;
        logic             ok;
    } t_vox;

endpackage

FILE: src/osva_cfg_regs.sv
// Configuration register file of the slice address generator.
// Depends on osva_pkg for register indexes, reset values and t_cfg.
module osva_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [osva_pkg::CFG_IDX_W-1:0]   i_index,
    input  logic [osva_pkg::CFG_DATA_W-1:0]  i_data,
    output osva_pkg::t_cfg                   o_cfg
);

    osva_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_x <= osva_pkg::SIZE_RESET;
            r_cfg.size_y <= osva_pkg::SIZE_RESET;
            r_cfg.size_z <= osva_pkg::SIZE_RESET;
            r_cfg.view_mode <= osva_pkg::VIEW_RADIOLOGIST;
            r_cfg.cut_plane <= osva_pkg::CUT_AXIAL;
            r_cfg.slice_index <= '0;
        end else if (i_we) begin
            unique case (i_index)
                osva_pkg::CFG_SIZE_X:      r_cfg.size_x <= i_data;
                osva_pkg::CFG_SIZE_Y:      r_cfg.size_y <= i_data;
                osva_pkg::CFG_SIZE_Z:      r_cfg.size_z <= i_data;
                osva_pkg::CFG_VIEW_MODE:   r_cfg.view_mode <= i_data[0];
                osva_pkg::CFG_CUT_PLANE:   r_cfg.cut_plane <= i_data[1:0];
                osva_pkg::CFG_SLICE_INDEX: r_cfg.slice_index <= i_data[8:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/osva_map.sv
// First pipeline stage: axis assignment, mirroring and range check of one pixel.
// Depends on osva_pkg for t_cfg, t_vox and the plane and view codes.
module osva_map #(
    parameter int MAX_DIM = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [osva_pkg::COORD_W-1:0]  i_row,
    input  logic [osva_pkg::COORD_W-1:0]  i_col,
    input  osva_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output osva_pkg::t_vox                o_vox
);

    logic                        r_valid;
    osva_pkg::t_vox              r_vox;
    osva_pkg::t_vox              n_vox;
    logic [osva_pkg::DIM_W-1:0]  w_row;
    logic [osva_pkg::DIM_W-1:0]  w_col;
    logic [osva_pkg::DIM_W-1:0]  w_slice;
    logic                        w_size_ok;

    function automatic logic [osva_pkg::DIM_W-1:0] f_orient(
        input logic [osva_pkg::DIM_W-1:0] v,
        input logic [osva_pkg::DIM_W-1:0] n,
        input logic                       m
    );
        return m ? (n - osva_pkg::DIM_W'(1) - v) : v;
    endfunction

    assign w_row = {1'b0, i_row};
    assign w_col = {1'b0, i_col};
    assign w_slice = {1'b0, i_cfg.slice_index};
    assign w_size_ok = (32'(i_cfg.size_x) <= MAX_DIM) && (32'(i_cfg.size_y) <= MAX_DIM)
                    && (32'(i_cfg.size_z) <= MAX_DIM);

    always_comb begin
        logic m_fixed;
        logic m_first;
        n_vox = '0;
        m_fixed = (i_cfg.view_mode == osva_pkg::VIEW_NEUROSURGEON);
        m_first = (i_cfg.view_mode == osva_pkg::VIEW_RADIOLOGIST);
        case (i_cfg.cut_plane)
            osva_pkg::CUT_CORONAL: begin
                n_vox.ok = w_slice < i_cfg.size_y && w_col < i_cfg.size_x
                        && w_row < i_cfg.size_z;
                n_vox.y = w_slice;
                n_vox.x = w_col;
                n_vox.z = f_orient(w_row, i_cfg.size_z, 1'b1);
            end
            osva_pkg::CUT_AXIAL: begin
                n_vox.ok = w_slice < i_cfg.size_z && w_col < i_cfg.size_x
                        && w_row < i_cfg.size_y;
                n_vox.z = f_orient(w_slice, i_cfg.size_z, m_fixed);
                n_vox.x = f_orient(w_col, i_cfg.size_x, m_fixed);
                n_vox.y = w_row;
            end
            default: begin
                n_vox.ok = w_slice < i_cfg.size_x && w_col < i_cfg.size_y
                        && w_row < i_cfg.size_z;
                n_vox.x = f_orient(w_slice, i_cfg.size_x, m_fixed);
                n_vox.y = f_orient(w_col, i_cfg.size_y, m_first);
                n_vox.z = f_orient(w_row, i_cfg.size_z, 1'b1);
            end
        endcase
        n_vox.ok = n_vox.ok && w_size_ok;
        if (!n_vox.ok) begin
            n_vox = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_vox <= n_vox;
        end
    end

    assign o_valid = r_valid;
    assign o_vox = r_vox;

endmodule

FILE: src/osva_addr.sv
// Stages two to four: linear address z*size_y*size_x + y*size_x + x; the multiplies sit in stages two and three.
// Depends on osva_pkg for t_cfg, t_vox and the field widths.
module osva_addr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  osva_pkg::t_vox                i_vox,
    input  osva_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output osva_pkg::t_vox                o_vox,
    output logic [osva_pkg::ADDR_W-1:0]   o_addr
);

    localparam int PROD_W = 2 * osva_pkg::DIM_W;
    localparam int ZP_W = 3 * osva_pkg::DIM_W;

    logic [2:0]                       r_valid;
    osva_pkg::t_vox                   r2_vox;
    osva_pkg::t_vox                   r3_vox;
    osva_pkg::t_vox                   r4_vox;
    logic [PROD_W-1:0]                r2_yx;
    logic [PROD_W-1:0]                r2_sxy;
    logic [osva_pkg::ADDR_W-1:0]      r3_zp;
    logic [PROD_W:0]                  r3_lo;
    logic [osva_pkg::ADDR_W-1:0]      r4_addr;
    logic [PROD_W-1:0]                w_yx;
    logic [PROD_W-1:0]                w_sxy;
    logic [ZP_W-1:0]                  w_zp;

    assign w_yx = i_vox.y * i_cfg.size_x;
    assign w_sxy = i_cfg.size_y * i_cfg.size_x;
    assign w_zp = r2_vox.z * r2_sxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r2_vox <= i_vox;
            r2_yx <= w_yx;
            r2_sxy <= w_sxy;
        end
        if (r_valid[0]) begin
            r3_vox <= r2_vox;
            r3_zp <= w_zp[osva_pkg::ADDR_W-1:0];
            r3_lo <= {1'b0, r2_yx} + (PROD_W + 1)'(r2_vox.x);
        end
        if (r_valid[1]) begin
            r4_vox <= r3_vox;
            r4_addr <= r3_zp + osva_pkg::ADDR_W'(r3_lo);
        end
    end

    assign o_valid = r_valid[2];
    assign o_vox = r4_vox;
    assign o_addr = r4_addr;

endmodule

FILE: src/orthogonal_slice_voxel_address.sv
// Orthogonal slice voxel address generator, top level.
// Depends on osva_pkg, osva_cfg_regs, osva_map and osva_addr.
//
// Usage:
//   Configuration: write a register through i_cfg_valid / o_cfg_ready with its index
//   on i_cfg_index (0 size_x, 1 size_y, 2 size_z, 3 view_mode, 4 cut_plane,
//   5 slice_index) and the value on i_cfg_data. Write only while no item is in flight.
//   Items: raise start with i_row / i_col; an item is taken at each clock edge with
//   start high and busy low. busy is low whenever reset is released, so one pixel
//   per clock is taken.
//   Results: o_strobe is high for one cycle with voxel x, y, z, the linear address
//   and o_in_range. Throughput is 1 item per cycle. An item passes through four
//   register stages: mapping and range check, then the y*size_x and size_y*size_x
//   multiplies, then the z multiply and the x add, then the final add.
//   Out-of-range pixels give o_in_range low and all other fields zero.
//   Reset: synchronous on i_rst_n; registers return to their reset values and every
//   item in flight is dropped. The receiver cannot stall; results are never held.
module orthogonal_slice_voxel_address #(
    parameter int MAX_DIM = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [osva_pkg::COORD_W-1:0]     i_row,
    input  logic [osva_pkg::COORD_W-1:0]     i_col,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [osva_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [osva_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                             o_strobe,
    output logic [osva_pkg::COORD_W-1:0]     o_voxel_x,
    output logic [osva_pkg::COORD_W-1:0]     o_voxel_y,
    output logic [osva_pkg::COORD_W-1:0]     o_voxel_z,
    output logic [osva_pkg::ADDR_W-1:0]      o_voxel_address,
    output logic                             o_in_range
);

    osva_pkg::t_cfg  w_cfg;
    osva_pkg::t_vox  w_map_vox;
    osva_pkg::t_vox  w_out_vox;
    logic            w_map_valid;
    logic            w_accept;

    assign busy = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept = start & ~busy;

    osva_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    osva_map #(
        .MAX_DIM (MAX_DIM)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_row   (i_row),
        .i_col   (i_col),
        .i_cfg   (w_cfg),
        .o_valid (w_map_valid),
        .o_vox   (w_map_vox)
    );

    osva_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_valid),
        .i_vox   (w_map_vox),
        .i_cfg   (w_cfg),
        .o_valid (o_strobe),
        .o_vox   (w_out_vox),
        .o_addr  (o_voxel_address)
    );

    assign o_voxel_x = w_out_vox.x[osva_pkg::COORD_W-1:0];
    assign o_voxel_y = w_out_vox.y[osva_pkg::COORD_W-1:0];
    assign o_voxel_z = w_out_vox.z[osva_pkg::COORD_W-1:0];
    assign o_in_range = w_out_vox.ok;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_strobe)
        else $error("item accepted without a result four cycles later");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(w_accept, 4))
        else $error("result strobe without an accepted item");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_in_range) |-> (o_voxel_address == '0 && o_voxel_x == '0
            && o_voxel_y == '0 && o_voxel_z == '0))
        else $error("out-of-range result carries nonzero fields");

    a_coord_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_in_range) |-> (w_out_vox.x < w_cfg.size_x
            && w_out_vox.y < w_cfg.size_y && w_out_vox.z < w_cfg.size_z))
        else $error("in-range result outside the volume");
`endif

endmodule
